[rtl/lfs_pkg.sv]
// Shared types, widths and constants of the line-follow steering controller.
package lfs_pkg;

  // Image geometry and the columns derived from it.
  localparam int IMG_COLS   = 80;
  localparam int CENTRE_Q4  = 16 * (IMG_COLS / 2 - 1);
  localparam int RIGHT_Q4   = 16 * (IMG_COLS - 1);
  localparam int WIDE_LIM   = IMG_COLS - 2;
  localparam int EDGE_LO    = 2;
  localparam int EDGE_HI    = IMG_COLS - 3;
  localparam int BELOW_LIM  = 60;
  localparam int MARK_HI    = IMG_COLS - 2;

  // Field widths of the transfers and registers.
  localparam int PIX_W      = 7;
  localparam int CQ_W       = 11;
  localparam int TURN_W     = 6;
  localparam int DUTY_W     = 12;
  localparam int SPEED_W    = 10;
  localparam int COEFF_W    = 11;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 7;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Internal widths.
  localparam int C_W        = $clog2(2 ** CQ_W + RIGHT_Q4);
  localparam int ERR_W      = C_W + 1;
  localparam int DIF_W      = C_W + 2;
  localparam int DCT_W      = CQ_W + 1;
  localparam int OPD_W      = 24;
  localparam int PROD_W     = 2 * OPD_W;
  localparam int ACC_W      = 36;
  localparam int X_W        = 22;
  localparam int QM_W       = 20;
  localparam int Q_W        = QM_W + 1;
  localparam int SV_W       = ERR_W + 5;
  localparam int MARKC_W    = C_W - 4;

  // Arithmetic constants.
  localparam int DUTY_MID   = 1500;
  localparam int ACC_BASE   = 5 * DUTY_MID * 4096;
  localparam int ACC_SH     = 12;
  localparam int RECIP5     = 838861;
  localparam int DIV5_SH    = 22;
  localparam int RECIP45    = 186414;
  localparam int DIV45_SH   = 23;
  localparam int COEFF_OFS  = 72;
  localparam int SPEED_BASE = 6400;
  localparam int SPEED_TURN = 208;
  localparam int SPEED_ERR  = 7;
  localparam int SPEED_MIN  = 150;
  localparam int SPEED_MAX  = 800;
  localparam int NO_TURN    = 59;
  localparam int ROW_NEAR   = 27;
  localparam int ROW_EXIT   = 22;
  localparam int ROW_ENTRY  = 43;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MIN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX   = 2'd3;

  // Reset values of the configuration registers.
  localparam int DUTY_MIN_RST = 1140;
  localparam int DUTY_MAX_RST = 1860;

  typedef struct packed {
    logic [PIX_W-1:0]  width_near;
    logic [PIX_W-1:0]  width_below;
    logic [PIX_W-1:0]  left_edge_near;
    logic [PIX_W-1:0]  right_edge_near;
    logic [CQ_W-1:0]   centre_exit;
    logic [CQ_W-1:0]   centre_near;
    logic [CQ_W-1:0]   centre_entry;
    logic [CQ_W-1:0]   centre_turn;
    logic [TURN_W-1:0] turn_row;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  servo_duty;
    logic [SPEED_W-1:0] speed_target;
    logic [COEFF_W-1:0] diff_coeff;
    logic [ROW_W-1:0]   marker_row;
    logic [COL_W-1:0]   marker_col;
    logic               marker_valid;
  } out_item_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop_gain;
    logic signed [GAIN_W-1:0] deriv_gain;
    logic [DUTY_W-1:0]        duty_min;
    logic [DUTY_W-1:0]        duty_max;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [OPD_W-1:0] a;
    logic signed [OPD_W-1:0] b;
  } mul_req_t;

endpackage

[rtl/lfs_if.sv]
// Valid/ready channel interfaces for the input and result transfers.
interface lfs_in_if;
  logic               valid;
  logic               ready;
  lfs_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lfs_out_if;
  logic               valid;
  logic               ready;
  lfs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/lfs_cfg.sv]
// Configuration register file: gains and duty limits, written by index.
module lfs_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lfs_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [lfs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output lfs_pkg::cfg_regs_t               regs
);

  lfs_pkg::cfg_regs_t regs_r;

  // Register writes; each register keeps the low bits of the write data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.prop_gain  <= '0;
      regs_r.deriv_gain <= '0;
      regs_r.duty_min   <= lfs_pkg::DUTY_W'(lfs_pkg::DUTY_MIN_RST);
      regs_r.duty_max   <= lfs_pkg::DUTY_W'(lfs_pkg::DUTY_MAX_RST);
    end else if (cfg_we) begin
      case (cfg_idx)
        lfs_pkg::CFG_PROP_GAIN:  regs_r.prop_gain  <= cfg_data[lfs_pkg::GAIN_W-1:0];
        lfs_pkg::CFG_DERIV_GAIN: regs_r.deriv_gain <= cfg_data[lfs_pkg::GAIN_W-1:0];
        lfs_pkg::CFG_DUTY_MIN:   regs_r.duty_min   <= cfg_data[lfs_pkg::DUTY_W-1:0];
        lfs_pkg::CFG_DUTY_MAX:   regs_r.duty_max   <= cfg_data[lfs_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

[rtl/lfs_mul.sv]
// Shared signed multiplier with a registered product.
module lfs_mul (
  input  logic                                clk,
  input  lfs_pkg::mul_req_t                   req,
  output logic signed [lfs_pkg::PROD_W-1:0]   prod
);

  logic signed [lfs_pkg::PROD_W-1:0] prod_r;

  // One product per cycle; the sequencer picks the operands.
  always_ff @(posedge clk) begin
    prod_r <= req.a * req.b;
  end

  assign prod = prod_r;

endmodule

[rtl/lfs_ctrl.sv]
// Sequencer and datapath: reference choice, error, duty, speed and coefficient.
module lfs_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  lfs_in_if.sink                              in_chan,
  lfs_out_if.source                           out_chan,
  input  lfs_pkg::cfg_regs_t                  cfg,
  output lfs_pkg::mul_req_t                   mul_req,
  input  logic signed [lfs_pkg::PROD_W-1:0]   prod
);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MP   = 4'd1;
  localparam logic [3:0] ST_MD   = 4'd2;
  localparam logic [3:0] ST_MT   = 4'd3;
  localparam logic [3:0] ST_SUM  = 4'd4;
  localparam logic [3:0] ST_ABS  = 4'd5;
  localparam logic [3:0] ST_DIV  = 4'd6;
  localparam logic [3:0] ST_CLMP = 4'd7;
  localparam logic [3:0] ST_COEF = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  localparam int C_W    = lfs_pkg::C_W;
  localparam int ERR_W  = lfs_pkg::ERR_W;
  localparam int DIF_W  = lfs_pkg::DIF_W;
  localparam int DCT_W  = lfs_pkg::DCT_W;
  localparam int OPD_W  = lfs_pkg::OPD_W;
  localparam int ACC_W  = lfs_pkg::ACC_W;
  localparam int X_W    = lfs_pkg::X_W;
  localparam int QM_W   = lfs_pkg::QM_W;
  localparam int Q_W    = lfs_pkg::Q_W;
  localparam int SV_W   = lfs_pkg::SV_W;
  localparam int MC_W   = lfs_pkg::MARKC_W;
  localparam int DUTY_W = lfs_pkg::DUTY_W;

  logic [3:0] state_r, state_nxt;

  logic                     in_xfer;
  logic                     out_wr;
  logic                     out_valid_r;
  lfs_pkg::out_item_t       out_r;

  logic signed [ERR_W-1:0]  prev_err_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [OPD_W-1:0]  err5_r;
  logic signed [OPD_W-1:0]  dif5_r;
  logic signed [OPD_W-1:0]  tf_r;
  logic signed [DCT_W-1:0]  dct_r;
  logic [lfs_pkg::TURN_W-1:0] turn_r;
  logic [lfs_pkg::ROW_W-1:0]  row_r;
  logic [MC_W-1:0]          col_r;
  logic                     mval_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [X_W-1:0]           x_r;
  logic                     neg_r;
  logic [lfs_pkg::SPEED_W-1:0] spd_r;
  logic [DUTY_W-1:0]        duty_r;

  // Capture-side signals.
  logic [C_W-1:0]           c_sel;
  logic [C_W-1:0]           c_sum;
  logic [lfs_pkg::ROW_W-1:0] row_sel;
  logic signed [ERR_W-1:0]  err_cap;
  logic signed [DIF_W-1:0]  dif_cap;
  logic signed [OPD_W-1:0]  err_ext;
  logic signed [OPD_W-1:0]  dif_ext;
  logic [OPD_W-1:0]         turn_ext;
  logic [MC_W-1:0]          col_cap;

  // Later-stage signals.
  logic [ACC_W-1:0]         acc_abs;
  logic [ERR_W-1:0]         aerr;
  logic signed [SV_W-1:0]   spd_raw;
  logic [SV_W-7:0]          spd_div;
  logic [lfs_pkg::SPEED_W-1:0] spd_calc;
  logic [QM_W-1:0]          q_mag;
  logic signed [Q_W-1:0]    q_s;
  logic signed [Q_W-1:0]    q_lo;
  logic signed [Q_W-1:0]    q_hi;
  logic signed [Q_W-1:0]    q_t;
  logic [DUTY_W-1:0]        duty_calc;
  logic [DUTY_W-1:0]        mag;
  logic [OPD_W-1:0]         coef_y;

  assign in_xfer        = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = (state_r == ST_IDLE);
  assign out_wr         = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

  // Reference choice and edge-loss correction of the centre column.
  always_comb begin
    c_sum   = C_W'(in_chan.data.centre_near) + C_W'(lfs_pkg::RIGHT_Q4);
    c_sel   = C_W'(in_chan.data.centre_near);
    row_sel = lfs_pkg::ROW_W'(lfs_pkg::ROW_NEAR);
    if (int'(in_chan.data.width_near) >= lfs_pkg::WIDE_LIM) begin
      c_sel   = C_W'(in_chan.data.centre_entry);
      row_sel = lfs_pkg::ROW_W'(lfs_pkg::ROW_ENTRY);
    end else if (int'(in_chan.data.width_below) >= lfs_pkg::BELOW_LIM) begin
      c_sel   = C_W'(in_chan.data.centre_exit);
      row_sel = lfs_pkg::ROW_W'(lfs_pkg::ROW_EXIT);
    end else if (int'(in_chan.data.left_edge_near) < lfs_pkg::EDGE_LO) begin
      c_sel   = C_W'(in_chan.data.centre_near) >> 1;
    end else if (int'(in_chan.data.right_edge_near) > lfs_pkg::EDGE_HI) begin
      c_sel   = c_sum >> 1;
    end
  end

  // Steering error, its difference and the scaled multiplier operands.
  always_comb begin
    err_cap  = $signed({1'b0, c_sel}) - $signed(ERR_W'(lfs_pkg::CENTRE_Q4));
    dif_cap  = DIF_W'(err_cap) - DIF_W'(prev_err_r);
    err_ext  = OPD_W'(err_cap);
    dif_ext  = OPD_W'(dif_cap);
    turn_ext = OPD_W'(in_chan.data.turn_row);
    col_cap  = c_sel[C_W-1:4];
  end

  // Speed target from the stored error and turn row.
  always_comb begin
    aerr     = err_r[ERR_W-1] ? ERR_W'(-err_r) : ERR_W'(err_r);
    spd_raw  = $signed(SV_W'(lfs_pkg::SPEED_BASE))
             - $signed(SV_W'(turn_r) * SV_W'(lfs_pkg::SPEED_TURN))
             - $signed(SV_W'(aerr) * SV_W'(lfs_pkg::SPEED_ERR));
    spd_div  = spd_raw[SV_W-2:5];
    if (spd_raw[SV_W-1] || int'(spd_div) < lfs_pkg::SPEED_MIN) begin
      spd_calc = lfs_pkg::SPEED_W'(lfs_pkg::SPEED_MIN);
    end else if (int'(spd_div) > lfs_pkg::SPEED_MAX) begin
      spd_calc = lfs_pkg::SPEED_W'(lfs_pkg::SPEED_MAX);
    end else begin
      spd_calc = lfs_pkg::SPEED_W'(spd_div);
    end
  end

  // Quotient sign, then the lower limit followed by the upper limit.
  always_comb begin
    acc_abs   = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    q_mag     = prod[lfs_pkg::DIV5_SH +: QM_W];
    q_s       = neg_r ? -$signed(Q_W'(q_mag)) : $signed(Q_W'(q_mag));
    q_lo      = $signed(Q_W'(cfg.duty_min));
    q_hi      = $signed(Q_W'(cfg.duty_max));
    q_t       = (q_s < q_lo) ? q_lo : q_s;
    q_t       = (q_t > q_hi) ? q_hi : q_t;
    duty_calc = q_t[DUTY_W-1:0];
    mag       = (int'(duty_r) >= lfs_pkg::DUTY_MID) ?
                duty_r - DUTY_W'(lfs_pkg::DUTY_MID) :
                DUTY_W'(lfs_pkg::DUTY_MID) - duty_r;
    coef_y    = (OPD_W'(mag) + OPD_W'(lfs_pkg::COEFF_OFS)) << 5;
  end

  // Operand selection for the shared multiplier. The coefficient product is
  // requested again while the result waits, so it is still there when written.
  always_comb begin
    mul_req.a = '0;
    mul_req.b = '0;
    case (state_r)
      ST_MP: begin
        mul_req.a = OPD_W'(cfg.prop_gain);
        mul_req.b = err5_r;
      end
      ST_MD: begin
        mul_req.a = OPD_W'(cfg.deriv_gain);
        mul_req.b = dif5_r;
      end
      ST_MT: begin
        mul_req.a = tf_r;
        mul_req.b = OPD_W'(dct_r);
      end
      ST_DIV: begin
        mul_req.a = $signed(OPD_W'(x_r));
        mul_req.b = $signed(OPD_W'(lfs_pkg::RECIP5));
      end
      ST_COEF, ST_DONE: begin
        mul_req.a = $signed(coef_y);
        mul_req.b = $signed(OPD_W'(lfs_pkg::RECIP45));
      end
      default: ;
    endcase
  end

  // Next state: a fixed walk through the steps, held at the end while the result register is full and not taken.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_MP;
      ST_MP:   state_nxt = ST_MD;
      ST_MD:   state_nxt = ST_MT;
      ST_MT:   state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_ABS;
      ST_ABS:  state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_CLMP;
      ST_CLMP: state_nxt = ST_COEF;
      ST_COEF: state_nxt = ST_DONE;
      ST_DONE: if (out_wr) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_err_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        prev_err_r <= err_cap;
      end
      if (out_wr) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      err_r  <= err_cap;
      err5_r <= (err_ext <<< 2) + err_ext;
      dif5_r <= (dif_ext <<< 2) + dif_ext;
      if (int'(in_chan.data.turn_row) != lfs_pkg::NO_TURN) begin
        tf_r <= $signed((turn_ext << 7) + (turn_ext << 6));
      end else begin
        tf_r <= '0;
      end
      dct_r  <= $signed({1'b0, in_chan.data.centre_turn})
              - $signed(DCT_W'(lfs_pkg::CENTRE_Q4));
      turn_r <= in_chan.data.turn_row;
      row_r  <= row_sel;
      col_r  <= col_cap;
      mval_r <= (int'(col_cap) > 1) && (int'(col_cap) < lfs_pkg::MARK_HI);
    end
    case (state_r)
      ST_MD:  acc_r <= $signed(ACC_W'(lfs_pkg::ACC_BASE)) + ACC_W'(prod);
      ST_MT:  acc_r <= acc_r + ACC_W'(prod);
      ST_SUM: acc_r <= acc_r + ACC_W'(prod);
      ST_ABS: begin
        x_r   <= acc_abs[lfs_pkg::ACC_SH +: X_W];
        neg_r <= acc_r[ACC_W-1];
        spd_r <= spd_calc;
      end
      ST_CLMP: duty_r <= duty_calc;
      default: ;
    endcase
    if (out_wr) begin
      out_r.servo_duty   <= duty_r;
      out_r.speed_target <= spd_r;
      out_r.diff_coeff   <= prod[lfs_pkg::DIV45_SH +: lfs_pkg::COEFF_W];
      out_r.marker_row   <= row_r;
      out_r.marker_col   <= col_r[lfs_pkg::COL_W-1:0];
      out_r.marker_valid <= mval_r;
    end
  end

  // The error of each transfer becomes the derivative history.
  a_prev_err: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (prev_err_r == err_r))
    else $error("derivative history does not match the captured error");

  // A finished result is never lost when the result register is empty.
  a_done_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_valid_r) |=> out_valid_r)
    else $error("finished result not written to the result register");

  // The speed target on offer stays inside its clamp.
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (int'(out_r.speed_target) >= lfs_pkg::SPEED_MIN &&
                     int'(out_r.speed_target) <= lfs_pkg::SPEED_MAX))
    else $error("speed target outside its limits");

  // The marker row is one of the three reference rows.
  a_marker_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (int'(out_r.marker_row) == lfs_pkg::ROW_NEAR ||
                     int'(out_r.marker_row) == lfs_pkg::ROW_EXIT ||
                     int'(out_r.marker_row) == lfs_pkg::ROW_ENTRY))
    else $error("marker row is not a reference row");

  // The multiplier is idle while no item is in flight.
  a_idle_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (mul_req.a == '0 && mul_req.b == '0))
    else $error("multiplier driven while the sequencer is idle");

endmodule

[rtl/line_follow_steer_pd_core.sv]
// Top level of the line-follow PD steering controller.
//
// One input transfer per camera frame carries the line features; one result
// transfer returns servo duty, speed target, differential coefficient and the
// marker position of the chosen reference point.
// Both channels are valid/ready: a transfer happens at a rising clock edge
// with valid and ready high. The configuration port writes the gains and the
// duty limits by index whenever cfg_we is high; it should only be used while
// no frame is in flight.
// The result reaches the result register after the sequencer has walked its
// steps from the input transfer. The shared multiplier serves five products
// in turn, so one frame holds the sequencer with input ready low, and a new
// frame is taken only once the sequencer is back in its idle state.
// The result register decouples the receiver: the next frame is taken as soon
// as the sequencer is free, even while the previous result still waits, and
// the sequencer holds its final step while a stalled result is not taken.
// Reset (rst_n low at a clock edge) clears the derivative history, empties
// the result register and restores the default gains and duty limits.
module line_follow_steer_pd_core (
  input  logic                              clk,
  input  logic                              rst_n,
  lfs_in_if.sink                            in_chan,
  lfs_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic [lfs_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [lfs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  lfs_pkg::cfg_regs_t                  cfg_regs;
  lfs_pkg::mul_req_t                   mul_req;
  logic signed [lfs_pkg::PROD_W-1:0]   mul_prod;

  // Configuration registers.
  lfs_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .regs     (cfg_regs)
  );

  // Shared multiplier.
  lfs_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (mul_prod)
  );

  // Sequencer and datapath.
  lfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg      (cfg_regs),
    .mul_req  (mul_req),
    .prod     (mul_prod)
  );

endmodule

[dv/tb_line_follow_steer_pd_core.sv]
// Self-checking testbench of the line-follow PD steering controller.
module tb_line_follow_steer_pd_core;
  import lfs_pkg::*;

  localparam int N_PHASES       = 10;
  localparam int RAND_PER_PHASE = 190;
  localparam int SETTLE_CYCLES  = 12;
  localparam int STALL_LIMIT    = 3000;
  localparam int HOLD_CYCLES    = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Configuration write port.
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = CFG_PROP_GAIN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Channel driving variables.
  logic      src_valid = 1'b0;
  in_item_t  src_data = '0;
  logic      sink_ready = 1'b0;

  lfs_in_if  in_chan ();
  lfs_out_if out_chan ();

  assign in_chan.valid  = src_valid;
  assign in_chan.data   = src_data;
  assign out_chan.ready = sink_ready;

  line_follow_steer_pd_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Frames waiting to be offered and steering results still to arrive.
  in_item_t  frame_q[$];
  out_item_t steer_exp_q[$];

  // Predictor copy of the gains, limits and derivative history.
  shortint           gain_p = 0;
  shortint           gain_d = 0;
  logic [DUTY_W-1:0] lim_lo = DUTY_W'(DUTY_MIN_RST);
  logic [DUTY_W-1:0] lim_hi = DUTY_W'(DUTY_MAX_RST);
  int                prev_err_q4 = 0;

  int fail_cnt = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int src_gap = 0;
  int src_calm = 0;
  int sink_wait = 0;
  int sink_calm = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Works out the steering result of one frame and advances the error history.
  function automatic out_item_t predict_steer(input in_item_t f);
    int     c, row, err, dif, duty, col, sp, mag, coeff, turn, ct, lo, hi;
    longint acc, q;
    out_item_t r;
    turn = f.turn_row;
    ct   = f.centre_turn;
    lo   = lim_lo;
    hi   = lim_hi;
    // Reference row choice, with edge-loss correction on the near row.
    if (int'(f.width_near) < WIDE_LIM) begin
      if (int'(f.width_below) < BELOW_LIM) begin
        c = f.centre_near;
        if (int'(f.left_edge_near) < EDGE_LO)
          c = c / 2;
        else if (int'(f.right_edge_near) > EDGE_HI)
          c = (c + RIGHT_Q4) / 2;
        row = ROW_NEAR;
      end else begin
        c   = f.centre_exit;
        row = ROW_EXIT;
      end
    end else begin
      c   = f.centre_entry;
      row = ROW_ENTRY;
    end
    err = c - CENTRE_Q4;
    dif = err - prev_err_q4;
    prev_err_q4 = err;
    // Duty in exact integer form, truncated toward zero, then limited.
    acc = 5 * (longint'(DUTY_MID) * 4096 + longint'(gain_p) * err + longint'(gain_d) * dif);
    if (turn != NO_TURN)
      acc += longint'(192) * turn * (ct - CENTRE_Q4);
    q = acc / 20480;
    if (q < lo) q = lo;
    if (q > hi) q = hi;
    duty  = int'(q);
    mag   = (duty >= DUTY_MID) ? duty - DUTY_MID : DUTY_MID - duty;
    coeff = (1280 * mag + 92160) / 1800;
    sp = (SPEED_BASE - SPEED_TURN * turn - SPEED_ERR * ((err < 0) ? -err : err)) / 32;
    if (sp < SPEED_MIN) sp = SPEED_MIN;
    if (sp > SPEED_MAX) sp = SPEED_MAX;
    col = c >> 4;
    r.servo_duty   = DUTY_W'(duty);
    r.speed_target = SPEED_W'(sp);
    r.diff_coeff   = COEFF_W'(coeff);
    r.marker_row   = ROW_W'(row);
    r.marker_col   = COL_W'(col);
    r.marker_valid = (col > 1) && (col < MARK_HI);
    return r;
  endfunction

  function automatic in_item_t frame_of(input int wn, input int wb, input int le, input int re,
                                        input int cx, input int cn, input int ce, input int ct,
                                        input int tr);
    in_item_t f;
    f.width_near      = PIX_W'(wn);
    f.width_below     = PIX_W'(wb);
    f.left_edge_near  = PIX_W'(le);
    f.right_edge_near = PIX_W'(re);
    f.centre_exit     = CQ_W'(cx);
    f.centre_near     = CQ_W'(cn);
    f.centre_entry    = CQ_W'(ce);
    f.centre_turn     = CQ_W'(ct);
    f.turn_row        = TURN_W'(tr);
    return f;
  endfunction

  // A pixel field: mostly in range, anywhere in the image width, or any 7-bit value.
  function automatic int pick_pix(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(lo, hi);
    if (r < 9) return $urandom_range(0, 79);
    return $urandom_range(0, 127);
  endfunction

  function automatic int pick_centre();
    if ($urandom_range(0, 4) != 0) return $urandom_range(0, 1264);
    return $urandom_range(0, 2047);
  endfunction

  // Random frame weighted toward each reference path and edge-loss case.
  function automatic in_item_t rand_frame();
    int wn, wb, le, re, tr, r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      wn = pick_pix(0, 77);
      wb = (r < 4) ? pick_pix(0, 59) : pick_pix(60, 80);
    end else begin
      wn = pick_pix(78, 80);
      wb = pick_pix(0, 80);
    end
    le = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) : pick_pix(2, 79);
    re = ($urandom_range(0, 4) == 0) ? $urandom_range(78, 79) : pick_pix(0, 77);
    r = $urandom_range(0, 9);
    if (r < 4)      tr = NO_TURN;
    else if (r < 8) tr = $urandom_range(0, 58);
    else            tr = $urandom_range(0, 63);
    return frame_of(wn, wb, le, re, pick_centre(), pick_centre(), pick_centre(),
                    pick_centre(), tr);
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Writes all four registers, one per cycle, and mirrors them in the predictor.
  task automatic program_steer(input int kp, input int kd, input int dmin, input int dmax);
    logic [CFG_IDX_W-1:0] idx [4];
    int                   vals [4];
    idx  = '{CFG_PROP_GAIN, CFG_DERIV_GAIN, CFG_DUTY_MIN, CFG_DUTY_MAX};
    vals = '{kp, kd, dmin, dmax};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_we   <= 1'b1;
      cfg_idx  <= idx[i];
      cfg_data <= CFG_DATA_W'(vals[i]);
      case (idx[i])
        CFG_PROP_GAIN:  gain_p = shortint'(vals[i]);
        CFG_DERIV_GAIN: gain_d = shortint'(vals[i]);
        CFG_DUTY_MIN:   lim_lo = DUTY_W'(vals[i]);
        CFG_DUTY_MAX:   lim_hi = DUTY_W'(vals[i]);
        default: ;
      endcase
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every frame is taken and answered, then lets the pipeline drain.
  task automatic wait_idle();
    while (frame_q.size() != 0 || src_valid || steer_exp_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Frame driver: offers queued frames with random gaps; predicts on each transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      src_valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (src_valid && in_chan.ready)
        steer_exp_q.push_back(predict_steer(src_data));
      if (!src_valid || in_chan.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          src_valid <= 1'b0;
        end else if (frame_q.size() > 0) begin
          src_data  <= frame_q.pop_front();
          src_valid <= 1'b1;
          if (src_calm > 0) begin
            src_calm--;
            src_gap = 0;
          end else begin
            src_gap = pick_gap();
            if ($urandom_range(0, 49) == 0) src_calm = 40;
          end
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (steer_exp_q.size() == 0) begin
          $error("steering result with no expectation waiting");
          fail_cnt++;
        end else begin
          out_item_t want;
          want = steer_exp_q.pop_front();
          if (out_chan.data.servo_duty !== want.servo_duty) begin
            $error("servo_duty: expected %0d, actual %0d", want.servo_duty,
                   out_chan.data.servo_duty);
            fail_cnt++;
          end
          if (out_chan.data.speed_target !== want.speed_target) begin
            $error("speed_target: expected %0d, actual %0d", want.speed_target,
                   out_chan.data.speed_target);
            fail_cnt++;
          end
          if (out_chan.data.diff_coeff !== want.diff_coeff) begin
            $error("diff_coeff: expected %0d, actual %0d", want.diff_coeff,
                   out_chan.data.diff_coeff);
            fail_cnt++;
          end
          if (out_chan.data.marker_row !== want.marker_row) begin
            $error("marker_row: expected %0d, actual %0d", want.marker_row,
                   out_chan.data.marker_row);
            fail_cnt++;
          end
          if (out_chan.data.marker_col !== want.marker_col) begin
            $error("marker_col: expected %0d, actual %0d", want.marker_col,
                   out_chan.data.marker_col);
            fail_cnt++;
          end
          if (out_chan.data.marker_valid !== want.marker_valid) begin
            $error("marker_valid: expected %0d, actual %0d", want.marker_valid,
                   out_chan.data.marker_valid);
            fail_cnt++;
          end
        end
        results_seen++;
        // Two long hold-offs let the block fill up and stall its input.
        if (results_seen == 300 || results_seen == 1200) begin
          sink_wait = HOLD_CYCLES;
        end else if (sink_calm > 0) begin
          sink_calm--;
          sink_wait = 0;
        end else begin
          sink_wait = pick_gap();
          if ($urandom_range(0, 49) == 0) sink_calm = 40;
        end
      end else if (sink_wait > 0) begin
        sink_wait--;
      end
      sink_ready <= (sink_wait == 0);
    end
  end

  // Cycles without any transfer, for the watchdog.
  always @(posedge clk) begin
    if ((src_valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus: reset, directed frames, then phases of random frames per setting.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        wait_idle();
        case (ph)
          1: program_steer(256, 128, 1000, 2000);
          2: program_steer(-32768, 32767, 0, 4095);
          3: program_steer(32767, -32768, 1700, 1300);
          4: program_steer(0, 0, 4095, 4095);
          5: program_steer(-200, 900, 0, 0);
          default: program_steer(int'($urandom_range(0, 4095)) - 2048,
                                 int'($urandom_range(0, 8191)) - 4096,
                                 $urandom_range(900, 1500), $urandom_range(1500, 2100));
        endcase
      end
      if (ph == 0) begin
        // Near row on the centre, and with either edge or both edges lost.
        frame_q.push_back(frame_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
        frame_q.push_back(frame_of(40, 40, 20, 60, 0, 624, 0, 0, NO_TURN));
        frame_q.push_back(frame_of(40, 59, 1, 60, 0, 1264, 0, 0, NO_TURN));
        frame_q.push_back(frame_of(77, 10, 2, 78, 0, 0, 0, 0, NO_TURN));
        frame_q.push_back(frame_of(30, 30, 0, 79, 0, 2047, 0, 0, NO_TURN));
        frame_q.push_back(frame_of(30, 30, 2, 77, 0, 700, 0, 0, NO_TURN));
        // Crossing exit and entry rows, including out-of-range widths.
        frame_q.push_back(frame_of(77, 60, 20, 60, 1264, 0, 0, 0, NO_TURN));
        frame_q.push_back(frame_of(10, 127, 0, 79, 2047, 0, 0, 0, NO_TURN));
        frame_q.push_back(frame_of(78, 80, 20, 60, 0, 0, 0, 0, NO_TURN));
        frame_q.push_back(frame_of(127, 0, 20, 60, 2047, 2047, 2047, 0, NO_TURN));
        // Turn compensation at both limits and for rows past the image.
        frame_q.push_back(frame_of(40, 40, 20, 60, 0, 624, 0, 2047, 58));
        frame_q.push_back(frame_of(40, 40, 20, 60, 0, 624, 0, 0, 58));
        frame_q.push_back(frame_of(40, 40, 20, 60, 0, 624, 0, 0, 63));
        frame_q.push_back(frame_of(40, 40, 20, 60, 0, 624, 0, 1264, 60));
        frame_q.push_back(frame_of(40, 40, 20, 60, 0, 0, 0, 624, 0));
        // Marker column either side of both validity bounds.
        frame_q.push_back(frame_of(40, 40, 20, 60, 0, 31, 0, 0, NO_TURN));
        frame_q.push_back(frame_of(40, 40, 20, 60, 0, 32, 0, 0, NO_TURN));
        frame_q.push_back(frame_of(40, 40, 20, 60, 0, 1247, 0, 0, NO_TURN));
        frame_q.push_back(frame_of(40, 40, 20, 60, 0, 1248, 0, 0, NO_TURN));
        // Every field at its all-ones value.
        frame_q.push_back(frame_of(127, 127, 127, 127, 2047, 2047, 2047, 2047, 63));
      end
      repeat (RAND_PER_PHASE) frame_q.push_back(rand_frame());
    end
    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
